FILE: hdl/ctsb_pkg.sv
// Package for the Cartesian tree stack builder: field widths, link codes and the
// result record passed from the controller to the output stage. No dependencies.
`default_nettype none

package ctsb_pkg;

    localparam int KEY_IN_W         = 32;  // width of the key field on the input port
    localparam int POS_W            = 5;   // width of a sequence position
    localparam int KIND_W           = 2;
    localparam int DEF_MAX_ELEMENTS = 32;
    localparam int DEF_KEY_WIDTH    = 32;

    typedef enum logic [KIND_W-1:0] {
        LINK_LEFT     = 2'd0,
        LINK_RIGHT    = 2'd1,
        LINK_ROOT     = 2'd2,
        LINK_OVERFLOW = 2'd3
    } t_link_kind;

    typedef struct packed {
        logic [POS_W-1:0] parent;
        logic [POS_W-1:0] child;
        t_link_kind       kind;
        logic             run_end;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/cartesian_tree_stack_builder.sv
// Cartesian tree stack builder, top level. Depends on ctsb_pkg, ctsb_ram, ctsb_ctrl, ctsb_out.
// Flow: an item is accepted, then pushed when it pops nothing; each pop is a compare
// followed by the stack RAM read that reloads the top, with no read when it empties the stack.
// A flush pops every stacked node the same way, root included. Results appear in the cycle after
// issue, and a result the sink has not taken stalls the controller. A new item is accepted only
// in the idle state. Synchronous active-low reset empties stack and sequence.
`default_nettype none

module cartesian_tree_stack_builder
    import ctsb_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int KEY_WIDTH    = DEF_KEY_WIDTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic signed [KEY_IN_W-1:0]  i_key_value,
    input  wire logic                        i_final_element,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [POS_W-1:0]                 o_parent_index,
    output logic [POS_W-1:0]                 o_child_index,
    output logic [KIND_W-1:0]                o_link_kind,
    output logic                             o_run_end
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int EW = KEY_WIDTH + POS_W;

    // The stack lives in one RAM of {ordered key, position} entries. The controller keeps
    // a copy of the top entry in registers, so a compare never waits on the RAM; only a
    // pop has to fetch the entry beneath it. Writes and reads never fall in one cycle,
    // so no forwarding path is needed.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    // Result requests pass through a single output register; the controller stalls
    // whenever that register is still full and the sink is not taking it.
    logic    res_push;
    logic    res_can_take;
    t_result res_req;
    t_result res_out;

    ctsb_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ELEMENTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ctsb_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .KEY_WIDTH    (KEY_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_key_value     (i_key_value),
        .i_final_element (i_final_element),
        .i_can_take      (res_can_take),
        .o_emit          (res_push),
        .o_result        (res_req),
        .o_we            (ram_we),
        .o_waddr         (ram_waddr),
        .o_wdata         (ram_wdata),
        .o_re            (ram_re),
        .o_raddr         (ram_raddr),
        .i_rdata         (ram_rdata)
    );

    ctsb_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_push),
        .i_result   (res_req),
        .o_can_take (res_can_take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (res_out)
    );

    assign o_parent_index = res_out.parent;
    assign o_child_index  = res_out.child;
    assign o_link_kind    = res_out.kind;
    assign o_run_end      = res_out.run_end;

endmodule

`default_nettype wire

FILE: hdl/ctsb_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module ctsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ctsb_out.sv
// Output register stage holding one result request until the sink takes it.
// Depends on ctsb_pkg.
`default_nettype none

module ctsb_out
    import ctsb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic         o_can_take,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic r_valid;
    t_result r_result;

    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ctsb_ctrl.sv
// Stack controller: compares, pops, pushes and flushes, keeping the top entry in
// registers and the rest in the stack RAM. Depends on ctsb_pkg.
`default_nettype none

module ctsb_ctrl
    import ctsb_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int KEY_WIDTH    = DEF_KEY_WIDTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [KEY_IN_W-1:0]           i_key_value,
    input  wire logic                                 i_final_element,
    input  wire logic                                 i_can_take,
    output logic                                      o_emit,
    output t_result                                   o_result,
    output logic                                      o_we,
    output logic [$clog2(MAX_ELEMENTS)-1:0]           o_waddr,
    output logic [KEY_WIDTH+POS_W-1:0]                o_wdata,
    output logic                                      o_re,
    output logic [$clog2(MAX_ELEMENTS)-1:0]           o_raddr,
    input  wire logic [KEY_WIDTH+POS_W-1:0]           i_rdata
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OVF,
        S_CMP,
        S_POP_WAIT,
        S_FLUSH,
        S_FL_WAIT
    } t_state;

    t_state                 r_state,   n_state;
    logic [KEY_WIDTH-1:0]   r_key,     n_key;
    logic                   r_final,   n_final;
    logic [CW-1:0]          r_depth,   n_depth;
    logic [CW-1:0]          r_count,   n_count;
    logic [KEY_WIDTH-1:0]   r_top_key, n_top_key;
    logic [POS_W-1:0]       r_top_pos, n_top_pos;
    logic [POS_W-1:0]       r_prev,    n_prev;
    logic                   r_have_prev, n_have_prev;

    logic [KEY_WIDTH+KEY_IN_W-1:0] key_wide;
    logic [KEY_WIDTH-1:0]          key_ord;
    logic [CW+POS_W-1:0]           count_wide;
    logic [POS_W-1:0]              count_pos;
    logic [CW-1:0]                 depth_dec;
    logic [CW-1:0]                 depth_dec2;
    logic                          full;
    logic                          pop_cond;

    // Flipping the sign bit turns two's complement order into unsigned order.
    assign key_wide   = {{KEY_WIDTH{1'b0}}, i_key_value};
    assign key_ord    = key_wide[KEY_WIDTH-1:0] ^ {1'b1, {(KEY_WIDTH-1){1'b0}}};
    assign count_wide = {{POS_W{1'b0}}, r_count};
    assign count_pos  = count_wide[POS_W-1:0];
    assign depth_dec  = r_depth - CW'(1);
    assign depth_dec2 = r_depth - CW'(2);
    assign full       = (r_count >= CW'(MAX_ELEMENTS));
    assign pop_cond   = (r_depth != '0) && (r_key > r_top_key);

    assign o_ready = (r_state == S_IDLE);
    assign o_waddr = r_depth[AW-1:0];
    assign o_wdata = {r_key, count_pos};
    assign o_raddr = depth_dec2[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_final     = r_final;
        n_depth     = r_depth;
        n_count     = r_count;
        n_top_key   = r_top_key;
        n_top_pos   = r_top_pos;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        o_emit      = 1'b0;
        o_we        = 1'b0;
        o_re        = 1'b0;
        o_result.parent  = r_top_pos;
        o_result.child   = r_prev;
        o_result.kind    = LINK_RIGHT;
        o_result.run_end = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key       = key_ord;
                    n_final     = i_final_element;
                    n_have_prev = 1'b0;
                    if (full) begin
                        n_state = i_final_element ? S_FLUSH : S_OVF;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_OVF: begin
                o_result.parent  = '0;
                o_result.child   = '0;
                o_result.kind    = LINK_OVERFLOW;
                o_result.run_end = 1'b1;
                if (i_can_take) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CMP, S_FLUSH: begin
                if ((r_state == S_CMP) ? pop_cond : (r_depth != '0)) begin
                    // Pop the top; every pop after the first links a right child.
                    if (!r_have_prev || i_can_take) begin
                        o_emit      = r_have_prev;
                        n_prev      = r_top_pos;
                        n_have_prev = 1'b1;
                        n_depth     = depth_dec;
                        if (depth_dec != '0) begin
                            o_re    = 1'b1;
                            n_state = (r_state == S_CMP) ? S_POP_WAIT : S_FL_WAIT;
                        end
                    end
                end else if (r_state == S_CMP) begin
                    // Push the new node; the last popped node is its left child.
                    o_result.parent  = count_pos;
                    o_result.kind    = LINK_LEFT;
                    o_result.run_end = !r_final;
                    if (!r_have_prev || i_can_take) begin
                        o_emit      = r_have_prev;
                        o_we        = 1'b1;
                        n_top_key   = r_key;
                        n_top_pos   = count_pos;
                        n_depth     = r_depth + CW'(1);
                        n_count     = r_count + CW'(1);
                        n_have_prev = 1'b0;
                        n_state     = r_final ? S_FLUSH : S_IDLE;
                    end
                end else begin
                    // Stack empty at the end of a flush: the last node popped is the root.
                    o_result.parent  = r_prev;
                    o_result.child   = '0;
                    o_result.kind    = LINK_ROOT;
                    o_result.run_end = 1'b1;
                    if (i_can_take) begin
                        o_emit  = r_have_prev;
                        n_count = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            S_POP_WAIT, S_FL_WAIT: begin
                n_top_key = i_rdata[KEY_WIDTH+POS_W-1:POS_W];
                n_top_pos = i_rdata[POS_W-1:0];
                n_state   = (r_state == S_POP_WAIT) ? S_CMP : S_FLUSH;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_count     <= '0;
            r_have_prev <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_count     <= n_count;
            r_have_prev <= n_have_prev;
        end
        r_key     <= n_key;
        r_final   <= n_final;
        r_top_key <= n_top_key;
        r_top_pos <= n_top_pos;
        r_prev    <= n_prev;
    end

    a_depth_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_count)
        else $error("stack depth exceeds element count");

    a_count_within_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMENTS))
        else $error("element count exceeds capacity");

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_can_take)
        else $error("result request issued while output stage is full");

    a_wait_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_WAIT || r_state == S_FL_WAIT) |-> $past(o_re))
        else $error("top reload without a preceding stack read");

    a_no_read_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> !o_re)
        else $error("stack read and write in the same cycle");

endmodule

`default_nettype wire

FILE: tb/ctsb_checker.sv
`timescale 1ns / 1ps
// Link checker for the Cartesian tree stack builder: watches both request channels, predicts
// the tree links of each accepted key and compares them with the results. Depends on ctsb_pkg.
module ctsb_checker
    import ctsb_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int KEY_WIDTH    = DEF_KEY_WIDTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire logic [KEY_IN_W-1:0] i_key_value,
    input  wire logic                i_final_element,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire logic [POS_W-1:0]    i_parent_index,
    input  wire logic [POS_W-1:0]    i_child_index,
    input  wire logic [KIND_W-1:0]   i_link_kind,
    input  wire logic                i_run_end,
    output int                       o_fail_count,
    output int                       o_pending
);

    // Predicted stack: keys are held as order-preserving unsigned ranks.
    logic [63:0]      node_rank [0:31];
    logic [POS_W-1:0] node_pos  [0:31];
    int               stack_fill    = 0;  // 0..32, six bits in the block
    int               next_position = 0;  // 0..32, six bits in the block
    t_result          link_queue [$];
    t_result          oldest;
    int               mismatch_count = 0;
    int               results_seen   = 0;

    assign o_fail_count = mismatch_count;

    // Low KEY_WIDTH bits as two's complement, sign bit flipped so that unsigned order holds.
    function automatic logic [63:0] rank_of(input logic [KEY_IN_W-1:0] raw);
        logic [63:0] mask;
        mask = {64{1'b1}} >> (64 - KEY_WIDTH);
        return ((64'(raw) & mask) ^ (64'd1 << (KEY_WIDTH - 1))) & mask;
    endfunction

    function automatic t_result link(input logic [POS_W-1:0] parent,
                                     input logic [POS_W-1:0] child, input t_link_kind kind);
        t_result r;
        r.parent  = parent;
        r.child   = child;
        r.kind    = kind;
        r.run_end = 1'b0;
        return r;
    endfunction

    // Works out the links that one key request causes and queues them in order.
    task automatic build_links(input logic [KEY_IN_W-1:0] raw, input logic fin);
        logic [63:0]      rank;
        logic [POS_W-1:0] prev;
        logic             have_prev;
        t_result          batch [$];
        rank      = rank_of(raw);
        prev      = '0;
        have_prev = 1'b0;
        if (next_position >= MAX_ELEMENTS) begin
            // Capacity reached: the key is dropped; a final one still flushes below.
            if (!fin) batch = {batch, link('0, '0, LINK_OVERFLOW)};
        end else begin
            while (stack_fill > 0 && rank > node_rank[stack_fill - 1]) begin
                if (have_prev)
                    batch = {batch, link(node_pos[stack_fill - 1], prev, LINK_RIGHT)};
                prev       = node_pos[stack_fill - 1];
                have_prev  = 1'b1;
                stack_fill = stack_fill - 1;
            end
            node_rank[stack_fill] = rank;
            node_pos[stack_fill]  = POS_W'(next_position);
            stack_fill            = stack_fill + 1;
            if (have_prev) batch = {batch, link(POS_W'(next_position), prev, LINK_LEFT)};
            next_position = next_position + 1;
        end
        if (fin) begin
            have_prev = 1'b0;
            while (stack_fill > 0) begin
                if (have_prev)
                    batch = {batch, link(node_pos[stack_fill - 1], prev, LINK_RIGHT)};
                prev       = node_pos[stack_fill - 1];
                have_prev  = 1'b1;
                stack_fill = stack_fill - 1;
            end
            if (have_prev) batch = {batch, link(prev, '0, LINK_ROOT)};
            next_position = 0;
        end
        if (batch.size() > 0) batch[batch.size() - 1].run_end = 1'b1;
        link_queue = {link_queue, batch};
    endtask

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stack_fill    = 0;
            next_position = 0;
        end else begin
            // Results first: a key accepted at this edge cannot have produced one yet.
            if (i_out_valid && i_out_ready) begin
                if (link_queue.size() == 0) begin
                    report_mismatch("result with none expected, link kind",
                                    int'(i_link_kind), -1);
                end else begin
                    oldest = link_queue.pop_front();
                    if (i_parent_index !== oldest.parent)
                        report_mismatch("parent index", int'(i_parent_index),
                                        int'(oldest.parent));
                    if (i_child_index !== oldest.child)
                        report_mismatch("child index", int'(i_child_index),
                                        int'(oldest.child));
                    if (i_link_kind !== oldest.kind)
                        report_mismatch("link kind", int'(i_link_kind), int'(oldest.kind));
                    if (i_run_end !== oldest.run_end)
                        report_mismatch("run end", int'(i_run_end), int'(oldest.run_end));
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) build_links(i_key_value, i_final_element);
        end
        o_pending <= link_queue.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for cartesian_tree_stack_builder: makes key requests and result
// back-pressure, and gives the verdict. Depends on ctsb_pkg, ctsb_checker and the block.
module testbench;
    import ctsb_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 300;        // cycles the result side holds off once
    localparam int SETTLE       = 100;        // covers a full flush of 32 nodes and the output stage
    localparam int CYCLE_LIMIT  = 2_000_000;

    // How the keys of one sequence are chosen.
    typedef enum int {
        STYLE_RANDOM,
        STYLE_TIES,
        STYLE_RISING,
        STYLE_FALLING,
        STYLE_EXTREME
    } t_key_style;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic [KEY_IN_W-1:0] in_key    = '0;
    logic                in_final  = 1'b0;
    logic                out_ready = 1'b0;
    logic                dut_ready;
    logic                dut_valid;
    logic [POS_W-1:0]    parent_index;
    logic [POS_W-1:0]    child_index;
    logic [KIND_W-1:0]   link_kind;
    logic                run_end;
    int                  fail_count;
    int                  pending;

    // Handshake between the stimulus and the result side for the long hold-off.
    logic                long_hold = 1'b0;
    logic                hold_done = 1'b0;

    bit                  calm = 1'b0;         // no sender gaps within the current sequence
    int                  sent = 0;            // random key requests offered so far
    int                  cycle_count = 0;

    always #5 clk = ~clk;

    cartesian_tree_stack_builder #(
        .MAX_ELEMENTS (DEF_MAX_ELEMENTS),
        .KEY_WIDTH    (DEF_KEY_WIDTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (dut_ready),
        .i_key_value     (in_key),
        .i_final_element (in_final),
        .o_valid         (dut_valid),
        .i_ready         (out_ready),
        .o_parent_index  (parent_index),
        .o_child_index   (child_index),
        .o_link_kind     (link_kind),
        .o_run_end       (run_end)
    );

    ctsb_checker #(
        .MAX_ELEMENTS (DEF_MAX_ELEMENTS),
        .KEY_WIDTH    (DEF_KEY_WIDTH)
    ) link_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (dut_ready),
        .i_key_value     (in_key),
        .i_final_element (in_final),
        .i_out_valid     (dut_valid),
        .i_out_ready     (out_ready),
        .i_parent_index  (parent_index),
        .i_child_index   (child_index),
        .i_link_kind     (link_kind),
        .i_run_end       (run_end),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Idle stretches: mostly a few cycles, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sequence lengths: mostly short, some medium, a few at or past the capacity of 32.
    function automatic int seq_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 8);
        if (r < 95) return $urandom_range(9, 31);
        return $urandom_range(32, 36);
    endfunction

    function automatic logic [KEY_IN_W-1:0] pick_key(input t_key_style style, input int idx);
        case (style)
            STYLE_TIES:    return 32'($urandom_range(0, 6)) - 32'd3;
            STYLE_RISING:  return 32'h8000_0000 + 32'(idx) * 32'd4096 + $urandom_range(0, 4095);
            STYLE_FALLING: return 32'h7FFF_FFFF - 32'(idx) * 32'd4096 - $urandom_range(0, 4095);
            STYLE_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:       return $urandom;
        endcase
    endfunction

    // Offers one key request and holds it until the block accepts it. Valid is only lowered
    // when a gap follows, so back-to-back requests never see valid dropped and raised in
    // the same time step.
    task automatic feed(input logic [KEY_IN_W-1:0] key, input logic fin);
        int gap;
        in_valid <= 1'b1;
        in_key   <= key;
        in_final <= fin;
        @(posedge clk);
        while (!dut_ready) @(posedge clk);
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // One whole sequence, the last key marked final so that the stack is flushed.
    task automatic send_seq(input int len, input t_key_style style);
        calm = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++) begin
            feed(pick_key(style, i), i == len - 1);
            sent++;
        end
        calm = 1'b0;
    endtask

    // Stops offering and waits until every predicted link has come out. The first edge lets
    // the checker's count catch up with a request accepted at the edge just passed.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Result side: random back-pressure with calm stretches, plus one long hold-off when the
    // stimulus asks for it. Each branch waits on the clock before ready changes again.
    initial begin : result_sink
        bit steady;
        steady = 1'b0;
        forever begin
            if (long_hold && !hold_done) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                if ($urandom_range(0, 9) == 0) steady = !steady;
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                if (!steady) begin
                    out_ready <= 1'b0;
                    repeat (idle_len()) @(posedge clk);
                end
            end
        end
    end

    // Watchdog: a lost result or a stuck handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone final key: nothing to link, only the root.
        feed(32'h0000_0000, 1'b1);
        // Most negative then most positive key: the second pops the first as its left child.
        feed(32'h8000_0000, 1'b0);
        feed(32'h7FFF_FFFF, 1'b1);
        // Equal keys never pop, so the flush chains them as right children.
        feed(32'd5, 1'b0);
        feed(32'd5, 1'b0);
        feed(32'd5, 1'b1);
        // A falling run then a larger key pops the whole stack at once.
        feed(32'd3, 1'b0);
        feed(32'd2, 1'b0);
        feed(32'd1, 1'b0);
        feed(32'd10, 1'b1);
        // Signed order around zero.
        feed(32'hFFFF_FFFF, 1'b0);
        feed(32'd1, 1'b0);
        feed(32'hFFFF_FFFE, 1'b1);
        // A tie with a stacked key among pops of smaller ones.
        feed(32'd4, 1'b0);
        feed(32'd9, 1'b0);
        feed(32'd4, 1'b0);
        feed(32'd4, 1'b0);
        feed(32'd9, 1'b1);

        // Capacity reached: one dropped key with an overflow request, then a dropped final
        // key that still flushes a deep stack of ties.
        send_seq(34, STYLE_TIES);
        // Capacity reached on the final key itself.
        send_seq(33, STYLE_FALLING);

        // The sender pauses until every link has come out.
        drain();
        repeat (SETTLE) @(posedge clk);

        // The result side holds off for a long stretch while requests keep coming, so the
        // block fills up and stalls its input.
        long_hold <= 1'b1;
        while (!hold_done) send_seq(seq_len(), t_key_style'($urandom_range(0, 4)));

        while (sent < RANDOM_ITEMS) send_seq(seq_len(), t_key_style'($urandom_range(0, 4)));

        drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: cartesian_tree_stack_builder.f
hdl/ctsb_pkg.sv
hdl/ctsb_ram.sv
hdl/ctsb_out.sv
hdl/ctsb_ctrl.sv
hdl/cartesian_tree_stack_builder.sv
tb/ctsb_checker.sv
tb/testbench.sv
